// File: rtl/bwu_pkg.sv
package bwu_pkg;

  localparam int COORD_BITS = 13;
  localparam int FRAC_BITS  = 16;

  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int RAW_W      = PROD_W + 1;
  localparam int MAG_W      = PROD_W;
  localparam int SUM_W      = MAG_W + 2;
  localparam int QUO_W      = FRAC_BITS + 1;
  localparam int OUT_W      = FRAC_BITS + 2;
  localparam int DIV_STAGES = QUO_W;

  localparam int IN_TDATA_W  = ((8 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [RAW_W-1:0]      raw_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       degenerate;
  } side_t;

endpackage

// File: rtl/bwu_div.sv
module bwu_div (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [2:0][bwu_pkg::MAG_W-1:0]       mag_i,
  input  logic [bwu_pkg::SUM_W-1:0]            den_i,
  input  bwu_pkg::side_t                       side_i,
  output logic [2:0][bwu_pkg::QUO_W-1:0]       quo_o,
  output bwu_pkg::side_t                       side_o
);
  import bwu_pkg::*;

  logic [SUM_W-1:0]            den_q  [DIV_STAGES];
  side_t                       side_q [DIV_STAGES];
  logic [2:0][SUM_W-1:0]       rem_q  [DIV_STAGES];
  logic [2:0][QUO_W-1:0]       quo_q  [DIV_STAGES];

  // One quotient bit per stage for each of the three lanes.
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    logic [2:0][SUM_W:0]   part;
    logic [SUM_W-1:0]      den;
    side_t                 side_in;
    logic [2:0][QUO_W-1:0] quo_in;
    logic [2:0][SUM_W-1:0] rem_d;
    logic [2:0][QUO_W-1:0] quo_d;

    if (j == 0) begin : g_first
      assign den     = den_i;
      assign side_in = side_i;
      assign quo_in  = '0;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign part[l] = (SUM_W + 1)'(mag_i[l]);
      end
    end else begin : g_next
      assign den     = den_q[j-1];
      assign side_in = side_q[j-1];
      assign quo_in  = quo_q[j-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign part[l] = {rem_q[j-1][l], 1'b0};
      end
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (part[l] >= {1'b0, den}) begin
          rem_d[l] = SUM_W'(part[l] - {1'b0, den});
          quo_d[l] = {quo_in[l][QUO_W-2:0], 1'b1};
        end else begin
          rem_d[l] = SUM_W'(part[l]);
          quo_d[l] = {quo_in[l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j]  <= den;
        side_q[j] <= side_in;
        rem_q[j]  <= rem_d;
        quo_q[j]  <= quo_d;
      end
    end
  end

  assign quo_o  = quo_q[DIV_STAGES-1];
  assign side_o = side_q[DIV_STAGES-1];

endmodule

// File: rtl/barycentric_weights_unit.sv
// Stages: differences, products, cross products, magnitudes, sum, divider, result, output.
// Throughput: one beat per cycle while the skid entry is free; the 17-stage restoring
// divider is fully pipelined. The output register and skid entry let the pipeline accept
// while the output stalls, until a result fills the skid entry. Reset: rst_ni clears all
// valid bits, the output buffer's too, asynchronously; datapath registers are not reset.
module barycentric_weights_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // a_x, a_y, b_x, b_y, c_x, c_y, pix_x, pix_y
  input  logic [bwu_pkg::IN_TDATA_W-1:0]    s_tdata_i,
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  // weight_a, weight_b, weight_c, zero fill
  output logic [bwu_pkg::OUT_TDATA_W-1:0]   m_tdata_o,
  // degenerate
  output logic                              m_tuser_o,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i
);
  import bwu_pkg::*;

  localparam int FRONT_STAGES = 5;
  localparam int NSTG         = FRONT_STAGES + DIV_STAGES + 1;

  typedef struct packed {
    logic                  degenerate;
    logic [2:0][OUT_W-1:0] w;
  } res_t;

  logic            en;
  logic [NSTG-1:0] vld_q;

  coord_t a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y;

  assign a_x = s_tdata_i[0*COORD_BITS +: COORD_BITS];
  assign a_y = s_tdata_i[1*COORD_BITS +: COORD_BITS];
  assign b_x = s_tdata_i[2*COORD_BITS +: COORD_BITS];
  assign b_y = s_tdata_i[3*COORD_BITS +: COORD_BITS];
  assign c_x = s_tdata_i[4*COORD_BITS +: COORD_BITS];
  assign c_y = s_tdata_i[5*COORD_BITS +: COORD_BITS];
  assign p_x = s_tdata_i[6*COORD_BITS +: COORD_BITS];
  assign p_y = s_tdata_i[7*COORD_BITS +: COORD_BITS];

  diff_t ab_x_q, ab_y_q, bc_x_q, bc_y_q, ca_x_q, ca_y_q;
  diff_t pa_x_q, pa_y_q, pb_x_q, pb_y_q, pc_x_q, pc_y_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ab_x_q <= diff_t'(a_x) - diff_t'(b_x);
      ab_y_q <= diff_t'(a_y) - diff_t'(b_y);
      bc_x_q <= diff_t'(b_x) - diff_t'(c_x);
      bc_y_q <= diff_t'(b_y) - diff_t'(c_y);
      ca_x_q <= diff_t'(c_x) - diff_t'(a_x);
      ca_y_q <= diff_t'(c_y) - diff_t'(a_y);
      pa_x_q <= diff_t'(p_x) - diff_t'(a_x);
      pa_y_q <= diff_t'(p_y) - diff_t'(a_y);
      pb_x_q <= diff_t'(p_x) - diff_t'(b_x);
      pb_y_q <= diff_t'(p_y) - diff_t'(b_y);
      pc_x_q <= diff_t'(p_x) - diff_t'(c_x);
      pc_y_q <= diff_t'(p_y) - diff_t'(c_y);
    end
  end

  prod_t wa_l_q, wa_r_q, wb_l_q, wb_r_q, wc_l_q, wc_r_q, wn_l_q, wn_r_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      wa_l_q <= prod_t'(bc_x_q) * prod_t'(pc_y_q);
      wa_r_q <= prod_t'(pc_x_q) * prod_t'(bc_y_q);
      wb_l_q <= prod_t'(ca_x_q) * prod_t'(pa_y_q);
      wb_r_q <= prod_t'(pa_x_q) * prod_t'(ca_y_q);
      wc_l_q <= prod_t'(ab_x_q) * prod_t'(pb_y_q);
      wc_r_q <= prod_t'(pb_x_q) * prod_t'(ab_y_q);
      wn_l_q <= prod_t'(ca_x_q) * prod_t'(bc_y_q);
      wn_r_q <= prod_t'(bc_x_q) * prod_t'(ca_y_q);
    end
  end

  raw_t raw_a_q, raw_b_q, raw_c_q;
  raw_t wind;
  logic wind_neg_q;

  assign wind = raw_t'(wn_l_q) - raw_t'(wn_r_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      raw_a_q    <= raw_t'(wa_l_q) - raw_t'(wa_r_q);
      raw_b_q    <= raw_t'(wb_l_q) - raw_t'(wb_r_q);
      raw_c_q    <= raw_t'(wc_l_q) - raw_t'(wc_r_q);
      wind_neg_q <= wind[RAW_W-1];
    end
  end

  logic [2:0][MAG_W-1:0] mag_d, mag3_q, mag4_q;
  logic [2:0]            rneg;
  logic                  wind3_q;
  side_t                 side3_q, side4_q;
  logic [SUM_W-1:0]      sum_q;

  assign rneg = {raw_c_q[RAW_W-1], raw_b_q[RAW_W-1], raw_a_q[RAW_W-1]};

  always_comb begin
    mag_d[0] = rneg[0] ? MAG_W'(-raw_a_q) : MAG_W'(raw_a_q);
    mag_d[1] = rneg[1] ? MAG_W'(-raw_b_q) : MAG_W'(raw_b_q);
    mag_d[2] = rneg[2] ? MAG_W'(-raw_c_q) : MAG_W'(raw_c_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag3_q             <= mag_d;
      side3_q.neg        <= rneg;
      side3_q.degenerate <= (raw_a_q == '0) && (raw_b_q == '0) && (raw_c_q == '0);
      wind3_q            <= wind_neg_q;
    end
  end

  // A negative winding flips the sign of the normalizer.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q              <= SUM_W'(mag3_q[0]) + SUM_W'(mag3_q[1]) + SUM_W'(mag3_q[2]);
      mag4_q             <= mag3_q;
      side4_q.neg        <= side3_q.neg ^ {3{wind3_q}};
      side4_q.degenerate <= side3_q.degenerate;
    end
  end

  logic [2:0][QUO_W-1:0] quo;
  side_t                 side_div;

  bwu_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (mag4_q),
    .den_i  (sum_q),
    .side_i (side4_q),
    .quo_o  (quo),
    .side_o (side_div)
  );

  res_t res_d, res_q;

  always_comb begin
    logic [OUT_W-1:0] wq;
    res_d.degenerate = side_div.degenerate;
    for (int l = 0; l < 3; l++) begin
      wq = OUT_W'(quo[l]);
      if (side_div.degenerate) begin
        res_d.w[l] = '0;
      end else if (side_div.neg[l]) begin
        res_d.w[l] = OUT_W'(0) - wq;
      end else begin
        res_d.w[l] = wq;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_tvalid_i};
    end
  end

  // Output register plus one skid entry; the pipeline runs while the skid entry is free.
  logic take;
  logic out_vld_q, skid_vld_q;
  res_t out_q, skid_q;

  assign en   = !skid_vld_q;
  assign take = en && vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || m_tready_i) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= take;
      end
    end else if (take) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_tready_i) begin
      out_q <= skid_vld_q ? skid_q : res_q;
    end else if (take) begin
      skid_q <= res_q;
    end
  end

  assign s_tready_o = en;
  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = OUT_TDATA_W'({out_q.w[2], out_q.w[1], out_q.w[0]});
  assign m_tuser_o  = out_q.degenerate;

endmodule
